// ===== rtl/core/spcm_pkg.sv =====
// Shared types, constants and helpers for the strict-priority cell multiplexer.
// No dependencies.
`timescale 1ns / 1ps
package spcm_pkg;

    localparam int NUM_PRIO      = 4;
    localparam int PRIO_W        = 2;
    localparam int MAX_CHANNELS  = 128;
    localparam int VCI_W         = 7;
    localparam int QUEUE_DEPTH   = 16;
    localparam int QPTR_W        = 4;
    localparam int QCNT_W        = 5;
    localparam int SLOT_ARRIVALS = 8;
    localparam int ABUF_IDX_W    = 3;
    localparam int ACNT_W        = 4;
    localparam int TAG_W         = 16;
    localparam int STAG_W        = TAG_W + PRIO_W;
    localparam int QADDR_W       = PRIO_W + QPTR_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [1:0] KIND_CELL = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_MAP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PRIO0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PRIO1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PRIO2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PRIO3  = 3'd5;

    localparam logic EV_DEPART = 1'b0;
    localparam logic EV_DROP   = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [VCI_W-1:0]  vci;
        logic [TAG_W-1:0]  cell_tag;
        logic [PRIO_W-1:0] prio_value;
    } t_in_item;

    typedef struct packed {
        logic              event_kind;
        logic [TAG_W-1:0]  out_tag;
        logic [PRIO_W-1:0] out_prio;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        SRV_IDLE,
        SRV_SERVE,
        SRV_SYNC
    } t_srv_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MOD,
        ST_ARR,
        ST_TIME,
        ST_DEQ,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic       done;
        logic [7:0] rem;
    } t_rem_rsp;

    function automatic logic [QCNT_W-1:0] cap_of(input logic [QCNT_W-1:0] lim);
        logic [QCNT_W-1:0] c;
        c = lim;
        if (c < QCNT_W'(1)) c = QCNT_W'(1);
        if (c > QCNT_W'(QUEUE_DEPTH)) c = QCNT_W'(QUEUE_DEPTH);
        return c;
    endfunction

endpackage

// ===== rtl/core/spcm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module spcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/spcm_rem.sv =====
// Bit-serial restoring remainder unit, 8-bit operands, one bit per cycle.
// Depends on spcm_pkg.
`timescale 1ns / 1ps
module spcm_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spcm_pkg::t_rem_req i_req,
    output spcm_pkg::t_rem_rsp o_rsp
);

    logic       r_busy, r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_rem, r_dvd, r_dsr;
    logic [8:0] trial;

    always_comb begin
        trial = {r_rem, r_dvd[7]};
        if (trial >= {1'b0, r_dsr}) begin
            trial = trial - {1'b0, r_dsr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= trial[7:0];
                r_dvd <= {r_dvd[6:0], 1'b0};
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/core/strict_priority_cell_multiplexer_top.sv =====
// Top level of the strict-priority cell multiplexer: sequencer, queues, map.
// Depends on spcm_pkg, spcm_ram, spcm_rem.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request at a
//   time: a cell arrival, a slot tick or a priority map write. o_in_stall is
//   high while a request is being worked on.
//   Work per request: a map write needs nothing further; an arrival adds a map
//   read, and a dropped arrival also hands over its result; a tick runs the
//   bit-serial slot phase remainder, takes the buffered arrivals in turn, does the
//   server update and any dequeue read, then hands over the last result.
//   Results (drops, departures) leave through o_out_valid / i_out_stall /
//   o_out_data, one register deep behind a one-entry hold, so a result is
//   flagged last only once the request is finished. A stalled receiver holds
//   the sequencer at the next result it must produce.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken; write
//   only while idle.
//   Reset: queues empty, server idle, map reads as highest priority through
//   per-entry valid bits, registers at their defaults. No clearing pass.
module strict_priority_cell_multiplexer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  spcm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spcm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spcm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW = spcm_pkg::PRIO_W;
    localparam int CW = spcm_pkg::QCNT_W;
    localparam int HW = spcm_pkg::QPTR_W;
    localparam int NP = spcm_pkg::NUM_PRIO;
    localparam int NA = spcm_pkg::SLOT_ARRIVALS;
    localparam int AW = spcm_pkg::ACNT_W;

    spcm_pkg::t_state    r_state, n_state;
    spcm_pkg::t_srv_mode r_mode, n_mode;

    logic [7:0]    r_st_time;
    logic          r_sync;
    logic [CW-1:0] r_lim [NP];

    logic [HW-1:0] r_qhead [NP], n_qhead [NP];
    logic [CW-1:0] r_qcnt  [NP], n_qcnt  [NP];

    logic [spcm_pkg::STAG_W-1:0] r_abuf [NA];
    logic [AW-1:0]  r_acount, n_acount;
    logic [PW-1:0]  r_top, n_top;
    logic [spcm_pkg::STAG_W-1:0] r_stag, n_stag;
    logic [7:0]     r_cd, n_cd, r_phase, n_phase, r_dd, n_dd;
    logic [AW-1:0]  r_idx, n_idx;
    logic [PW-1:0]  r_dq, n_dq;
    spcm_pkg::t_in_item  r_req;
    spcm_pkg::t_out_item r_hold, n_hold, r_out, n_out;
    logic           r_hold_v, n_hold_v, r_out_v, n_out_v;
    logic [spcm_pkg::MAX_CHANNELS-1:0] r_map_vld;
    logic           r_look_vld;

    logic           abuf_we;
    logic [spcm_pkg::STAG_W-1:0] abuf_wdata;
    logic           map_we;
    logic [PW-1:0]  map_rdata;
    logic           q_we;
    logic [spcm_pkg::QADDR_W-1:0] q_waddr, q_raddr;
    logic [spcm_pkg::TAG_W-1:0]   q_wdata, q_rdata;
    spcm_pkg::t_rem_req rem_req;
    spcm_pkg::t_rem_rsp rem_rsp;

    logic [7:0]    st;
    logic          can_emit, want_emit, go;
    spcm_pkg::t_out_item emit_item;
    logic [spcm_pkg::STAG_W-1:0] ent;
    logic [PW-1:0] ent_p, look_p, hq;
    logic          fits, direct, any_q, expire;
    logic [7:0]    cd_dec;

    assign o_in_stall  = (r_state != spcm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign st       = (r_st_time == 8'd0) ? 8'd1 : r_st_time;
    assign can_emit = !r_hold_v || !r_out_v || !i_out_stall;

    spcm_ram #(.WIDTH(PW), .DEPTH(spcm_pkg::MAX_CHANNELS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (i_in_data.vci),
        .i_wdata (i_in_data.prio_value),
        .i_raddr (i_in_data.vci),
        .o_rdata (map_rdata)
    );

    spcm_ram #(.WIDTH(spcm_pkg::TAG_W), .DEPTH(NP * spcm_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    spcm_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    always_comb begin
        ent    = r_abuf[r_idx[spcm_pkg::ABUF_IDX_W-1:0]];
        ent_p  = ent[spcm_pkg::STAG_W-1:spcm_pkg::TAG_W];
        look_p = r_look_vld ? map_rdata : PW'(NP - 1);
        fits   = r_qcnt[ent_p] < spcm_pkg::cap_of(r_lim[ent_p]);
        direct = (r_mode == spcm_pkg::SRV_IDLE) && (ent_p == r_top);
        cd_dec = (r_cd != 8'd0) ? r_cd - 8'd1 : 8'd0;
        expire = (r_mode != spcm_pkg::SRV_IDLE) && (cd_dec == 8'd0);
        hq     = '0;
        any_q  = 1'b0;
        for (int q = 0; q < NP; q++) begin
            if (r_qcnt[q] != '0) begin
                hq    = PW'(q);
                any_q = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_qhead    = r_qhead;
        n_qcnt     = r_qcnt;
        n_acount   = r_acount;
        n_top      = r_top;
        n_stag     = r_stag;
        n_cd       = r_cd;
        n_phase    = r_phase;
        n_dd       = r_dd;
        n_idx      = r_idx;
        n_dq       = r_dq;
        n_hold     = r_hold;
        n_hold_v   = r_hold_v;
        n_out      = r_out;
        n_out_v    = r_out_v;
        abuf_we    = 1'b0;
        abuf_wdata = {look_p, r_req.cell_tag};
        map_we     = 1'b0;
        q_we       = 1'b0;
        q_waddr    = {ent_p, r_qhead[ent_p] + r_qcnt[ent_p][HW-1:0]};
        q_wdata    = ent[spcm_pkg::TAG_W-1:0];
        q_raddr    = {hq, r_qhead[hq]};
        rem_req.start    = 1'b0;
        rem_req.dividend = r_phase;
        rem_req.divisor  = st;
        want_emit  = 1'b0;
        emit_item  = '0;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            spcm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.kind)
                        spcm_pkg::KIND_CELL: n_state = spcm_pkg::ST_LOOK;
                        spcm_pkg::KIND_TICK: begin
                            rem_req.start = 1'b1;
                            n_state       = spcm_pkg::ST_MOD;
                        end
                        spcm_pkg::KIND_MAP: map_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            spcm_pkg::ST_LOOK: begin
                if (r_acount >= AW'(NA)) begin
                    want_emit = 1'b1;
                    emit_item = '{spcm_pkg::EV_DROP, r_req.cell_tag, look_p, 1'b0};
                    n_state   = spcm_pkg::ST_FLUSH;
                end else begin
                    abuf_we  = 1'b1;
                    n_acount = r_acount + AW'(1);
                    if (look_p > r_top) n_top = look_p;
                    n_state  = spcm_pkg::ST_IDLE;
                end
            end
            spcm_pkg::ST_MOD: begin
                if (rem_rsp.done) begin
                    n_dd    = rem_rsp.rem;
                    n_idx   = '0;
                    n_state = spcm_pkg::ST_ARR;
                end
            end
            spcm_pkg::ST_ARR: begin
                if (r_idx == r_acount) begin
                    n_state = spcm_pkg::ST_TIME;
                end else begin
                    n_idx = r_idx + AW'(1);
                    if (direct && !(r_sync && r_dd != 8'd0)) begin
                        n_stag = ent;
                        n_mode = spcm_pkg::SRV_SERVE;
                        n_cd   = st;
                    end else if (fits) begin
                        q_we          = 1'b1;
                        n_qcnt[ent_p] = r_qcnt[ent_p] + CW'(1);
                        if (direct) begin
                            n_mode = spcm_pkg::SRV_SYNC;
                            n_cd   = st - r_dd;
                        end
                    end else begin
                        want_emit = 1'b1;
                        emit_item = '{spcm_pkg::EV_DROP, ent[spcm_pkg::TAG_W-1:0], ent_p, 1'b0};
                    end
                end
            end
            spcm_pkg::ST_TIME: begin
                n_acount = '0;
                n_top    = '0;
                n_phase  = ({1'b0, r_phase} + 9'd1 >= {1'b0, st}) ? 8'd0 : r_phase + 8'd1;
                n_state  = spcm_pkg::ST_FLUSH;
                if (r_mode != spcm_pkg::SRV_IDLE) n_cd = cd_dec;
                if (expire) begin
                    if (r_mode == spcm_pkg::SRV_SERVE) begin
                        want_emit = 1'b1;
                        emit_item = '{spcm_pkg::EV_DEPART, r_stag[spcm_pkg::TAG_W-1:0],
                                      r_stag[spcm_pkg::STAG_W-1:spcm_pkg::TAG_W], 1'b0};
                    end
                    if (any_q) begin
                        n_dq    = hq;
                        n_state = spcm_pkg::ST_DEQ;
                    end else begin
                        n_mode = spcm_pkg::SRV_IDLE;
                    end
                end
            end
            spcm_pkg::ST_DEQ: begin
                n_stag        = {r_dq, q_rdata};
                n_mode        = spcm_pkg::SRV_SERVE;
                n_cd          = st;
                n_qhead[r_dq] = r_qhead[r_dq] + HW'(1);
                n_qcnt[r_dq]  = r_qcnt[r_dq] - CW'(1);
                n_state       = spcm_pkg::ST_FLUSH;
            end
            spcm_pkg::ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = spcm_pkg::ST_IDLE;
                end else if (!r_out_v || !i_out_stall) begin
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = spcm_pkg::ST_IDLE;
                end
            end
            default: n_state = spcm_pkg::ST_IDLE;
        endcase

        go = !want_emit || can_emit;
        if (!go) begin
            n_state  = r_state;
            n_mode   = r_mode;
            n_qhead  = r_qhead;
            n_qcnt   = r_qcnt;
            n_acount = r_acount;
            n_top    = r_top;
            n_stag   = r_stag;
            n_cd     = r_cd;
            n_phase  = r_phase;
            n_idx    = r_idx;
            n_dq     = r_dq;
            q_we     = 1'b0;
        end else if (want_emit) begin
            if (r_hold_v) begin
                n_out   = r_hold;
                n_out_v = 1'b1;
            end
            n_hold   = emit_item;
            n_hold_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spcm_pkg::ST_IDLE;
            r_mode     <= spcm_pkg::SRV_IDLE;
            r_st_time  <= 8'd1;
            r_sync     <= 1'b0;
            r_acount   <= '0;
            r_top      <= '0;
            r_stag     <= '0;
            r_cd       <= '0;
            r_phase    <= '0;
            r_idx      <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_map_vld  <= '0;
            for (int q = 0; q < NP; q++) begin
                r_lim[q]   <= CW'(1);
                r_qhead[q] <= '0;
                r_qcnt[q]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_acount <= n_acount;
            r_top    <= n_top;
            r_stag   <= n_stag;
            r_cd     <= n_cd;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_qhead  <= n_qhead;
            r_qcnt   <= n_qcnt;
            if (map_we) r_map_vld[i_in_data.vci] <= 1'b1;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    spcm_pkg::REG_SERVICE_TIME: r_st_time <= i_cfg_data;
                    spcm_pkg::REG_SYNC_MODE:    r_sync    <= i_cfg_data[0];
                    spcm_pkg::REG_LIMIT_PRIO0:  r_lim[0]  <= i_cfg_data[CW-1:0];
                    spcm_pkg::REG_LIMIT_PRIO1:  r_lim[1]  <= i_cfg_data[CW-1:0];
                    spcm_pkg::REG_LIMIT_PRIO2:  r_lim[2]  <= i_cfg_data[CW-1:0];
                    spcm_pkg::REG_LIMIT_PRIO3:  r_lim[3]  <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == spcm_pkg::ST_IDLE && i_in_valid) r_req <= i_in_data;
        r_look_vld <= r_map_vld[i_in_data.vci];
        r_dd   <= n_dd;
        r_dq   <= n_dq;
        r_hold <= n_hold;
        r_out  <= n_out;
        if (abuf_we) r_abuf[r_acount[spcm_pkg::ABUF_IDX_W-1:0]] <= abuf_wdata;
    end

    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spcm_pkg::ST_IDLE |-> !r_hold_v)
        else $error("result left in hold while idle");

    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spcm_pkg::ST_IDLE && r_mode != spcm_pkg::SRV_IDLE) |-> r_cd != 8'd0)
        else $error("busy server with zero countdown");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acount <= AW'(NA))
        else $error("slot buffer overrun");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spcm_pkg::ST_TIME && n_state != spcm_pkg::ST_TIME) |=> r_acount == '0)
        else $error("slot buffer not cleared by tick");

endmodule
